/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked at every rising edge out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/rvalu_pkg.sv */
`timescale 1ns / 1ps
package rvalu_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned FUNC_W   = 10;
  localparam int unsigned DEST_W   = 5;
  localparam int unsigned SHAMT_W  = 5;
  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);
  localparam int unsigned DIV_CNT_W = $clog2(XLEN);

  localparam logic [6:0] F7_BASE = 7'd0;
  localparam logic [6:0] F7_ALT  = 7'd32;
  localparam logic [6:0] F7_MULDIV = 7'd1;

  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
    OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU, OP_REM, OP_REMU, OP_ILL
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [XLEN-1:0]   a;
    logic [XLEN-1:0]   b;
    logic [DEST_W-1:0] dest;
  } item_t;

  // selector to operation
  function automatic op_e decode_op(input logic [FUNC_W-1:0] func);
    logic [6:0] f7;
    logic [2:0] f3;
    op_e        op;
    f7 = func[9:3];
    f3 = func[2:0];
    op = OP_ILL;
    unique case (f7)
      F7_BASE: begin
        unique case (f3)
          3'd0: op = OP_ADD;
          3'd1: op = OP_SLL;
          3'd2: op = OP_SLT;
          3'd3: op = OP_SLTU;
          3'd4: op = OP_XOR;
          3'd5: op = OP_SRL;
          3'd6: op = OP_OR;
          default: op = OP_AND;
        endcase
      end
      F7_ALT: begin
        unique case (f3)
          3'd0: op = OP_SUB;
          3'd5: op = OP_SRA;
          default: op = OP_ILL;
        endcase
      end
      F7_MULDIV: begin
        unique case (f3)
          3'd0: op = OP_MUL;
          3'd1: op = OP_MULH;
          3'd2: op = OP_MULHSU;
          3'd3: op = OP_MULHU;
          3'd4: op = OP_DIV;
          3'd5: op = OP_DIVU;
          3'd6: op = OP_REM;
          default: op = OP_REMU;
        endcase
      end
      default: op = OP_ILL;
    endcase
    return op;
  endfunction

endpackage

/* hw/rtl/rvalu_front.sv */
`timescale 1ns / 1ps
module rvalu_front (
  input  logic                          push,
  output logic                          full,
  input  logic [rvalu_pkg::FUNC_W-1:0]  func_i,
  input  logic [rvalu_pkg::XLEN-1:0]    first_operand_i,
  input  logic [rvalu_pkg::XLEN-1:0]    second_operand_i,
  input  logic [rvalu_pkg::DEST_W-1:0]  dest_index_i,
  input  logic                          q_full_i,
  output logic                          q_wr_o,
  output rvalu_pkg::item_t              q_item_o
);
  import rvalu_pkg::*;

  // classify the transaction and hand it to the queue
  assign full          = q_full_i;
  assign q_wr_o        = push && !q_full_i;
  assign q_item_o.op   = decode_op(func_i);
  assign q_item_o.a    = first_operand_i;
  assign q_item_o.b    = second_operand_i;
  assign q_item_o.dest = dest_index_i;

endmodule

/* hw/rtl/rvalu_queue.sv */
`timescale 1ns / 1ps
module rvalu_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  rvalu_pkg::item_t wr_item_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             valid_o,
  output rvalu_pkg::item_t rd_item_o
);
  import rvalu_pkg::*;

  item_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o    = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_item_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

/* hw/rtl/rvalu_back.sv */
`timescale 1ns / 1ps
module rvalu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  rvalu_pkg::item_t              q_item_i,
  output logic                          q_rd_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [rvalu_pkg::DEST_W-1:0]  dest_out_o,
  output logic [rvalu_pkg::XLEN-1:0]    value_out_o,
  output logic                          legal_o
);
  import rvalu_pkg::*;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_MUL = 2'd1;
  localparam logic [1:0] ST_DIV = 2'd2;
  localparam logic [1:0] ST_FIN = 2'd3;

  logic [1:0]            state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic [XLEN-1:0]       out_val_q, out_val_d;
  logic [DEST_W-1:0]     out_dest_q, out_dest_d;
  logic                  out_legal_q, out_legal_d;
  logic                  out_free, out_wr;

  op_e                   op_q;
  logic [DEST_W-1:0]     dest_q;
  logic [2*XLEN-1:0]     prod_q;
  logic [XLEN-1:0]       quo_q, rem_q, dvsr_q, a_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  zero_q, negq_q, negr_q;

  logic                  is_mul, is_div, take;
  logic [XLEN-1:0]       a, b, alu_val, mul_val, div_val;
  logic [SHAMT_W-1:0]    sh;
  logic                  sgn_div;
  logic [XLEN:0]         a_ext, b_ext, trial;
  logic [XLEN-1:0]       rem_sh;

  assign a       = q_item_i.a;
  assign b       = q_item_i.b;
  assign sh      = b[SHAMT_W-1:0];
  assign is_mul  = (q_item_i.op == OP_MUL) || (q_item_i.op == OP_MULH) ||
                   (q_item_i.op == OP_MULHSU) || (q_item_i.op == OP_MULHU);
  assign is_div  = (q_item_i.op == OP_DIV) || (q_item_i.op == OP_DIVU) ||
                   (q_item_i.op == OP_REM) || (q_item_i.op == OP_REMU);
  assign sgn_div = (q_item_i.op == OP_DIV) || (q_item_i.op == OP_REM);
  assign out_free = !out_valid_q || pop;
  assign take    = q_valid_i && (state_q == ST_RUN) && (out_free || is_mul || is_div);
  assign q_rd_o  = take;

  // combinational alu
  always_comb begin
    unique case (q_item_i.op)
      OP_ADD:  alu_val = a + b;
      OP_SUB:  alu_val = a - b;
      OP_SLL:  alu_val = a << sh;
      OP_SLT:  alu_val = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
      OP_SLTU: alu_val = {{(XLEN-1){1'b0}}, (a < b)};
      OP_XOR:  alu_val = a ^ b;
      OP_SRL:  alu_val = a >> sh;
      OP_SRA:  alu_val = XLEN'($signed(a) >>> sh);
      OP_OR:   alu_val = a | b;
      OP_AND:  alu_val = a & b;
      default: alu_val = '0;
    endcase
  end

  // operand sign extension for the multiplier
  assign a_ext = {((q_item_i.op == OP_MULH) || (q_item_i.op == OP_MULHSU)) && a[XLEN-1], a};
  assign b_ext = {(q_item_i.op == OP_MULH) && b[XLEN-1], b};

  // product word select
  assign mul_val = (op_q == OP_MUL) ? prod_q[XLEN-1:0] : prod_q[2*XLEN-1:XLEN];

  // one restoring divide step per cycle
  assign trial  = {rem_q, quo_q[XLEN-1]} - {1'b0, dvsr_q};
  assign rem_sh = {rem_q[XLEN-2:0], quo_q[XLEN-1]};

  // divide result fix-up: sign, divide by zero
  always_comb begin
    if ((op_q == OP_DIV) || (op_q == OP_DIVU)) begin
      div_val = zero_q ? '1 : (negq_q ? (XLEN'(0) - quo_q) : quo_q);
    end else begin
      div_val = zero_q ? a_q : (negr_q ? (XLEN'(0) - rem_q) : rem_q);
    end
  end

  // sequencer and result register write
  always_comb begin
    state_d     = state_q;
    out_wr      = 1'b0;
    out_val_d   = out_val_q;
    out_dest_d  = out_dest_q;
    out_legal_d = out_legal_q;
    unique case (state_q)
      ST_RUN: begin
        if (take) begin
          if (is_mul) begin
            state_d = ST_MUL;
          end else if (is_div) begin
            state_d = ST_DIV;
          end else begin
            out_wr      = 1'b1;
            out_val_d   = alu_val;
            out_dest_d  = q_item_i.dest;
            out_legal_d = (q_item_i.op != OP_ILL);
          end
        end
      end
      ST_MUL: begin
        if (out_free) begin
          out_wr      = 1'b1;
          out_val_d   = mul_val;
          out_dest_d  = dest_q;
          out_legal_d = 1'b1;
          state_d     = ST_RUN;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_wr      = 1'b1;
          out_val_d   = div_val;
          out_dest_d  = dest_q;
          out_legal_d = 1'b1;
          state_d     = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
    out_valid_d = out_wr || (out_valid_q && !pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      out_val_q   <= out_val_d;
      out_dest_q  <= out_dest_d;
      out_legal_q <= out_legal_d;
    end
  end

  // multiply and divide working registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q   <= q_item_i.op;
      dest_q <= q_item_i.dest;
    end
    if (take && is_mul) begin
      prod_q <= (2*XLEN)'($signed(a_ext) * $signed(b_ext));
    end
    if (take && is_div) begin
      a_q    <= a;
      quo_q  <= (sgn_div && a[XLEN-1]) ? (XLEN'(0) - a) : a;
      dvsr_q <= (sgn_div && b[XLEN-1]) ? (XLEN'(0) - b) : b;
      rem_q  <= '0;
      cnt_q  <= DIV_CNT_W'(XLEN - 1);
      zero_q <= (b == '0);
      negq_q <= sgn_div && (a[XLEN-1] ^ b[XLEN-1]);
      negr_q <= sgn_div && a[XLEN-1];
    end else if (state_q == ST_DIV) begin
      rem_q <= trial[XLEN] ? rem_sh : trial[XLEN-1:0];
      quo_q <= {quo_q[XLEN-2:0], !trial[XLEN]};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign empty       = !out_valid_q;
  assign dest_out_o  = out_dest_q;
  assign value_out_o = out_val_q;
  assign legal_o     = out_legal_q;

endmodule

/* hw/rtl/rv32im_register_alu_unit.sv */
`timescale 1ns / 1ps
// channel  | handshake            | fields
// ---------+----------------------+----------------------------------------------
// input    | push / full          | func_i, first_operand_i, second_operand_i,
//          |                      | dest_index_i
// result   | empty / pop          | dest_out_o, value_out_o, legal_o
//
// alu ops, illegal selectors: queue, then result register; one per cycle while popped.
// multiplies hold the execute side: one 33x33 multiplier, then word select in ST_MUL.
// divide and remainder hold it: one restoring step per cycle, then sign fix-up.
// a two-entry queue lets pushes continue while the execute side waits on pop or a divide.
// rst_ni clears the queue, the sequencer and the result valid; no clearing pass.
module rv32im_register_alu_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [rvalu_pkg::FUNC_W-1:0]  func_i,
  input  logic [rvalu_pkg::XLEN-1:0]    first_operand_i,
  input  logic [rvalu_pkg::XLEN-1:0]    second_operand_i,
  input  logic [rvalu_pkg::DEST_W-1:0]  dest_index_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [rvalu_pkg::DEST_W-1:0]  dest_out_o,
  output logic [rvalu_pkg::XLEN-1:0]    value_out_o,
  output logic                          legal_o
);
  import rvalu_pkg::*;

  logic  q_full, q_wr, q_rd, q_valid;
  item_t wr_item, rd_item;

  // decode side
  rvalu_front u_front (
    .push             (push),
    .full             (full),
    .func_i           (func_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .dest_index_i     (dest_index_i),
    .q_full_i         (q_full),
    .q_wr_o           (q_wr),
    .q_item_o         (wr_item)
  );

  // decoupling queue
  rvalu_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_item_i (wr_item),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .valid_o   (q_valid),
    .rd_item_o (rd_item)
  );

  // execute side
  rvalu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (rd_item),
    .q_rd_o      (q_rd),
    .empty       (empty),
    .pop         (pop),
    .dest_out_o  (dest_out_o),
    .value_out_o (value_out_o),
    .legal_o     (legal_o)
  );

endmodule

/* hw/rtl/rvalu_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rvalu_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [rvalu_pkg::DEST_W-1:0]  dest_out_o,
  input logic [rvalu_pkg::XLEN-1:0]    value_out_o,
  input logic                          legal_o
);
  import rvalu_pkg::*;

  logic [DEST_W+XLEN:0] res_w;

  // result fields seen as one word
  assign res_w = {dest_out_o, value_out_o, legal_o};

  // a waiting result holds until popped
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(res_w))
  // illegal selectors carry a zero word
  `ASSERT_IMPL(a_ill_zero, clk_i, rst_ni, !empty && !legal_o, value_out_o == '0)
  // queue and result slot come out of reset empty
  `ASSERT_IMPL(a_rst, clk_i, rst_ni, $rose(rst_ni), !full && empty)
  // a waiting result never shows unknown bits
  `ASSERT_IMPL(a_known, clk_i, rst_ni, !empty, !$isunknown(res_w))

endmodule

bind rv32im_register_alu_unit rvalu_checker u_rvalu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .dest_out_o  (dest_out_o),
  .value_out_o (value_out_o),
  .legal_o     (legal_o)
);

/* dv/tb_rv32im_register_alu_unit.sv */
`timescale 1ns / 1ps
module tb_rv32im_register_alu_unit;
  import rvalu_pkg::*;

  localparam int unsigned N_RANDOM = 800;

  // selector fields
  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SRL = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;

  typedef struct {
    logic [DEST_W-1:0] dest;
    logic [XLEN-1:0]   value;
    logic              legal;
  } wb_t;

  // expected write-back queue and checker
  class alu_scoreboard;
    wb_t expected_wb[$];
    int  n_errors;
    int  n_checked;
    int  n_illegal;
    int  n_divs;

    function automatic logic [XLEN-1:0] mag(input logic [XLEN-1:0] x);
      return x[XLEN-1] ? -x : x;
    endfunction

    function automatic wb_t compute(input logic [FUNC_W-1:0] func, input logic [XLEN-1:0] a,
                                    input logic [XLEN-1:0] b, input logic [DEST_W-1:0] d);
      wb_t             r;
      logic [6:0]      f7;
      logic [2:0]      f3;
      logic [4:0]      sh;
      logic [63:0]     prod;
      logic [XLEN-1:0] q;
      f7 = func[9:3];
      f3 = func[2:0];
      sh = b[4:0];
      r.dest = d;
      r.value = '0;
      r.legal = 1'b1;
      if (f7 == F7_BASE) begin
        case (f3)
          F3_ADD:  r.value = a + b;
          F3_SLL:  r.value = a << sh;
          F3_SLT:  r.value = {31'd0, $signed(a) < $signed(b)};
          F3_SLTU: r.value = {31'd0, a < b};
          F3_XOR:  r.value = a ^ b;
          F3_SRL:  r.value = a >> sh;
          F3_OR:   r.value = a | b;
          default: r.value = a & b;
        endcase
      end else if (f7 == F7_ALT && f3 == F3_ADD) begin
        r.value = a - b;
      end else if (f7 == F7_ALT && f3 == F3_SRL) begin
        r.value = $signed(a) >>> sh;
      end else if (f7 == F7_MULDIV) begin
        case (f3)
          3'd0: begin
            prod = {32'd0, a} * {32'd0, b};
            r.value = prod[31:0];
          end
          3'd1: begin
            prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
            r.value = prod[63:32];
          end
          3'd2: begin
            prod = {{32{a[31]}}, a} * {32'd0, b};
            r.value = prod[63:32];
          end
          3'd3: begin
            prod = {32'd0, a} * {32'd0, b};
            r.value = prod[63:32];
          end
          3'd4: begin
            if (b == 0) r.value = '1;
            else begin
              q = mag(a) / mag(b);
              r.value = (a[31] ^ b[31]) ? -q : q;
            end
          end
          3'd5: r.value = (b == 0) ? '1 : a / b;
          3'd6: begin
            if (b == 0) r.value = a;
            else begin
              q = mag(a) % mag(b);
              r.value = a[31] ? -q : q;
            end
          end
          default: r.value = (b == 0) ? a : a % b;
        endcase
      end else begin
        r.legal = 1'b0;
      end
      return r;
    endfunction

    function void note_push(input logic [FUNC_W-1:0] func, input logic [XLEN-1:0] a,
                            input logic [XLEN-1:0] b, input logic [DEST_W-1:0] d);
      wb_t r;
      r = compute(func, a, b, d);
      if (!r.legal) n_illegal++;
      if (func[9:3] == F7_MULDIV && func[2]) n_divs++;
      expected_wb.insert(expected_wb.size(), r);
    endfunction

    function void check_pop(input logic [DEST_W-1:0] d, input logic [XLEN-1:0] v,
                            input logic l);
      wb_t e;
      if (expected_wb.size() == 0) begin
        $display("%0t: unexpected transaction dest=%0d value=%h legal=%b", $time, d, v, l);
        n_errors++;
        return;
      end
      e = expected_wb.pop_front();
      n_checked++;
      if (d !== e.dest) begin
        $display("%0t: dest mismatch expected %0d actual %0d", $time, e.dest, d);
        n_errors++;
      end
      if (v !== e.value) begin
        $display("%0t: value mismatch expected %h actual %h", $time, e.value, v);
        n_errors++;
      end
      if (l !== e.legal) begin
        $display("%0t: legal mismatch expected %b actual %b", $time, e.legal, l);
        n_errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [FUNC_W-1:0] func_i;
  logic [XLEN-1:0]   first_operand_i;
  logic [XLEN-1:0]   second_operand_i;
  logic [DEST_W-1:0] dest_index_i;
  logic              empty;
  logic              pop;
  logic [DEST_W-1:0] dest_out_o;
  logic [XLEN-1:0]   value_out_o;
  logic              legal_o;

  alu_scoreboard sb;
  bit            quiet_phase;
  bit            hold_pop;

  rv32im_register_alu_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .func_i(func_i), .first_operand_i(first_operand_i),
    .second_operand_i(second_operand_i), .dest_index_i(dest_index_i),
    .empty(empty), .pop(pop), .dest_out_o(dest_out_o),
    .value_out_o(value_out_o), .legal_o(legal_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // accepted transactions on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_push(func_i, first_operand_i, second_operand_i, dest_index_i);
      if (pop && !empty) sb.check_pop(dest_out_o, value_out_o, legal_o);
    end
  end

  // random selector: mostly legal operations, divides kept moderate
  function automatic logic [FUNC_W-1:0] pick_func();
    int k;
    k = $urandom_range(0, 19);
    if (k < 8) return {F7_BASE, 3'($urandom_range(0, 7))};
    if (k < 10) return {F7_ALT, ($urandom_range(0, 1) != 0) ? F3_SRL : F3_ADD};
    if (k < 17) return {F7_MULDIV, 3'($urandom_range(0, 7))};
    return FUNC_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [XLEN-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return 32'h80000000;
      3: return 32'h7fffffff;
      4: return 32'($urandom_range(0, 40));
      default: return $urandom();
    endcase
  endfunction

  // offer one transaction and wait for it to be accepted
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [XLEN-1:0] a,
                         input logic [XLEN-1:0] b, input logic [DEST_W-1:0] d);
    push <= 1'b1;
    func_i <= f;
    first_operand_i <= a;
    second_operand_i <= b;
    dest_index_i <= d;
    do @(posedge clk_i); while (full);
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 14);
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // wait on the clock first so the last accepted transaction is already noted
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_wb.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_pop) begin
        pop <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_pop = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        pop <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // stimulus
  initial begin
    logic [XLEN-1:0] dir_a[4];
    logic [XLEN-1:0] dir_b[4];
    sb = new();
    rst_ni = 1'b0;
    push = 1'b0;
    func_i = '0;
    first_operand_i = '0;
    second_operand_i = '0;
    dest_index_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation, divide by zero, signed overflow, wide shifts
    for (int f3 = 0; f3 < 8; f3++) send_op({F7_BASE, 3'(f3)}, 32'h80000001, 32'hffffffe3, 5'd31);
    send_op({F7_ALT, F3_ADD}, 32'h0, 32'h1, 5'd0);
    send_op({F7_ALT, F3_SRL}, 32'h80000000, 32'h0000003f, 5'd1);
    for (int f3 = 0; f3 < 8; f3++) send_op({F7_MULDIV, 3'(f3)}, 32'h80000000, 32'hffffffff, 5'd2);
    for (int f3 = 4; f3 < 8; f3++) send_op({F7_MULDIV, 3'(f3)}, 32'hfffffff9, 32'h0, 5'd3);
    send_op(10'h3ff, 32'hffffffff, 32'hffffffff, 5'd4);
    send_op({F7_ALT, F3_OR}, 32'h12345678, 32'h1, 5'd5);
    dir_a = '{32'hfffffff9, 32'h7, 32'hfffffff9, 32'h7};
    dir_b = '{32'h2, 32'hfffffffe, 32'hfffffffe, 32'h2};
    for (int i = 0; i < 4; i++) send_op({F7_MULDIV, 3'd6}, dir_a[i], dir_b[i], 5'(i));
    wait_drained();

    // receiver holds off while the sender keeps offering
    hold_pop = 1'b1;
    for (int i = 0; i < 12; i++) send_op({F7_BASE, 3'($urandom_range(0, 7))}, $urandom(),
                                        $urandom(), 5'($urandom_range(0, 31)));
    wait_drained();

    // random part, quiet for the last stretch
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 100) quiet_phase = 1'b1;
      sender_gap();
      send_op(pick_func(), pick_word(), pick_word(), 5'($urandom_range(0, 31)));
    end
    wait_drained();
    repeat (50) @(posedge clk_i);

    $display("checked %0d write-backs, %0d illegal selectors, %0d divides/remainders",
             sb.n_checked, sb.n_illegal, sb.n_divs);
    if (sb.n_errors == 0 && sb.expected_wb.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // timeout
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
